FILE: rtl/hsrc_pkg.sv
// ----------------------------------------------------------------------------
// hsrc_pkg
// types, codes and constants shared by the half-step stepper ramp controller
// ----------------------------------------------------------------------------
package hsrc_pkg;

  // field widths
  localparam int RATE_W     = 16;  // step_rate
  localparam int RAMP_W     = 24;  // ramp_steps, divider remainder
  localparam int TICK_W     = 20;  // tick_rate, interval, wait counter
  localparam int COUNT_IN_W = 24;  // step_count field
  localparam int COILS_W    = 4;
  localparam int PHASE_W    = 3;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // divider sequencing
  localparam int                  DIV_CNT_W      = 5;
  localparam logic [DIV_CNT_W-1:0] RATE_DIV_STEPS = 5'd16;
  localparam logic [DIV_CNT_W-1:0] TICK_DIV_STEPS = 5'd20;

  localparam logic [TICK_W-1:0] TICK_RATE_RST = 20'd1000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE  = 2'd2;

  // half-step coil patterns: A+, A+B+, B+, B+A-, A-, A-B-, B-, A+B-
  localparam logic [COILS_W-1:0] COIL_TABLE [8] = '{
    4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9
  };

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_ROTATE  = 2'd1,
    OP_LOCK    = 2'd2,
    OP_DISABLE = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    RS_IDLE = 2'd0,
    RS_RUN  = 2'd1,
    RS_LOCK = 2'd2,
    RS_OFF  = 2'd3
  } run_status_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SELECT,
    CS_MULT,
    CS_LAUNCH,
    CS_DIV_RATE,
    CS_DIV_TICK
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic sel_en;
    logic mul_en;
    logic start_rate;
    logic start_tick;
    logic load_interval;
  } hsrc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic step_now;
    logic need_div;
    logic div_busy;
    logic out_busy;
  } hsrc_stat_t;

endpackage

FILE: rtl/hsrc_if.sv
// ----------------------------------------------------------------------------
// hsrc channel interfaces
// command input, result output and register write channels
// ----------------------------------------------------------------------------
interface hsrc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        direction;
  logic [23:0] step_count;

  modport source (output valid, op, direction, step_count, input ready);
  modport sink   (input valid, op, direction, step_count, output ready);
endinterface

interface hsrc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] coils;
  logic [1:0] status;
  logic       done_res;
  logic [2:0] phase;

  modport source (output valid, coils, status, done_res, phase, input ready);
  modport sink   (input valid, coils, status, done_res, phase, output ready);
endinterface

interface hsrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/hsrc_div.sv
// ----------------------------------------------------------------------------
// hsrc_div
// restoring divider, one quotient bit per cycle, shared by both divisions
// ----------------------------------------------------------------------------
module hsrc_div import hsrc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [RAMP_W-1:0]    rem_i,
  input  logic [TICK_W-1:0]    dvd_i,
  input  logic [RAMP_W-1:0]    divisor_i,
  input  logic [DIV_CNT_W-1:0] iters_i,
  output logic                 busy_o,
  output logic [TICK_W-1:0]    quot_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [RAMP_W-1:0]    rem_q;
  logic [RAMP_W-1:0]    div_q;
  logic [TICK_W-1:0]    quo_q;
  logic [RAMP_W:0]      shifted;
  logic [RAMP_W:0]      diff;
  logic                 ge;

  // partial remainder takes the next dividend bit from the top of the quotient register
  assign shifted = {rem_q, quo_q[TICK_W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = ~diff[RAMP_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= iters_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      quo_q <= dvd_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[RAMP_W-1:0] : shifted[RAMP_W-1:0];
      quo_q <= {quo_q[TICK_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

FILE: rtl/hsrc_dp.sv
// ----------------------------------------------------------------------------
// hsrc_dp
// motor state, config registers, ramp select, multiplier and interval divider
// ----------------------------------------------------------------------------
module hsrc_dp import hsrc_pkg::*; #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hsrc_cmd_t             cmd_i,
  output hsrc_stat_t            stat_o,
  input  logic [OP_W-1:0]       in_op_i,
  input  logic                  in_dir_i,
  input  logic [COUNT_IN_W-1:0] in_count_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [COILS_W-1:0]    out_coils_o,
  output logic [STATUS_W-1:0]   out_status_o,
  output logic                  out_done_o,
  output logic [PHASE_W-1:0]    out_phase_o
);

  localparam int CmpW = (COUNT_WIDTH > RAMP_W ? COUNT_WIDTH : RAMP_W) + 1;
  localparam int PrdW = RATE_W + COUNT_WIDTH;

  // config
  logic [RATE_W-1:0] step_rate_q;
  logic [RAMP_W-1:0] ramp_steps_q;
  logic [TICK_W-1:0] tick_rate_q;

  // motor state
  logic [PHASE_W-1:0]     phase_q, phase_d;
  logic [TICK_W-1:0]      wait_q, wait_d;
  logic [TICK_W-1:0]      interval_q;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] target_q, target_d;
  logic                   dir_q, dir_d;
  run_status_e            run_q, run_d;
  logic [COILS_W-1:0]     coil_q, coil_d;
  logic                   done_q, done_d;
  logic                   out_valid_q;

  // ramp pipeline
  logic [COUNT_WIDTH-1:0] x_q, x_d;
  logic                   need_div_q, need_div_d;
  logic [PrdW-1:0]        prod_q;

  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] new_target;
  logic [COUNT_WIDTH-1:0] left;
  logic [CmpW-1:0]        t_w, d_w, r_w, left_w;
  logic [RATE_W-1:0]      rate_raw, rate_eff;
  logic                   div_busy;
  logic [TICK_W-1:0]      quot;
  logic [RAMP_W-1:0]      div_rem;
  logic [TICK_W-1:0]      div_dvd;
  logic [RAMP_W-1:0]      div_divisor;
  logic [DIV_CNT_W-1:0]   div_iters;

  // config writes, out-of-range indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_rate_q  <= '0;
      ramp_steps_q <= '0;
      tick_rate_q  <= TICK_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_STEP_RATE:  step_rate_q  <= cfg_data_i[RATE_W-1:0];
        REG_RAMP_STEPS: ramp_steps_q <= cfg_data_i[RAMP_W-1:0];
        REG_TICK_RATE:  tick_rate_q  <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cnt_inc    = cnt_q + COUNT_WIDTH'(1);
  assign new_target = COUNT_WIDTH'(in_count_i);

  assign stat_o.step_now = (op_e'(in_op_i) == OP_TICK) && (run_q == RS_RUN) &&
                           !(wait_q < interval_q);
  assign stat_o.need_div = need_div_q;
  assign stat_o.div_busy = div_busy;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  // item processing at the accepting edge
  always_comb begin
    phase_d  = phase_q;
    wait_d   = wait_q;
    cnt_d    = cnt_q;
    target_d = target_q;
    dir_d    = dir_q;
    run_d    = run_q;
    coil_d   = coil_q;
    done_d   = 1'b0;
    case (op_e'(in_op_i))
      OP_TICK: begin
        if (run_q == RS_RUN) begin
          if (wait_q < interval_q) begin
            wait_d = wait_q + TICK_W'(1);
          end else begin
            wait_d  = '0;
            coil_d  = COIL_TABLE[phase_q];
            phase_d = dir_q ? phase_q - PHASE_W'(1) : phase_q + PHASE_W'(1);
            cnt_d   = cnt_inc;
            if (cnt_inc == target_q) begin
              run_d  = RS_LOCK;
              done_d = 1'b1;
            end
          end
        end
      end
      OP_ROTATE: begin
        target_d = new_target;
        cnt_d    = '0;
        dir_d    = in_dir_i;
        wait_d   = '0;
        if (new_target == '0) begin
          coil_d = COIL_TABLE[phase_q];
          run_d  = RS_LOCK;
          done_d = 1'b1;
        end else begin
          run_d = RS_RUN;
        end
      end
      OP_LOCK: begin
        coil_d = COIL_TABLE[phase_q];
        run_d  = RS_LOCK;
      end
      default: begin
        coil_d = '0;
        run_d  = RS_OFF;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      wait_q      <= '0;
      interval_q  <= '0;
      cnt_q       <= '0;
      target_q    <= '0;
      dir_q       <= 1'b0;
      run_q       <= RS_IDLE;
      coil_q      <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        phase_q  <= phase_d;
        wait_q   <= wait_d;
        cnt_q    <= cnt_d;
        target_q <= target_d;
        dir_q    <= dir_d;
        run_q    <= run_d;
        coil_q   <= coil_d;
        done_q   <= done_d;
      end
      if (cmd_i.load_interval) begin
        interval_q <= quot;
      end
      if (cmd_i.accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ramp segment: accelerate, cruise or decelerate
  assign left   = (target_q >= cnt_q) ? target_q - cnt_q : '0;
  assign t_w    = CmpW'(target_q);
  assign d_w    = CmpW'(cnt_q);
  assign r_w    = CmpW'(ramp_steps_q);
  assign left_w = CmpW'(left);

  always_comb begin
    need_div_d = 1'b1;
    x_d        = left;
    if ((r_w << 1) > t_w) begin
      x_d = (d_w < (t_w >> 1)) ? cnt_q : left;
    end else if (d_w < r_w) begin
      x_d = cnt_q;
    end else if (left_w < r_w) begin
      x_d = left;
    end else begin
      need_div_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel_en) begin
      x_q        <= x_d;
      need_div_q <= need_div_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= PrdW'(step_rate_q) * PrdW'(x_q);
    end
  end

  // rate of zero counts as one
  assign rate_raw = need_div_q ? quot[RATE_W-1:0] : step_rate_q;
  assign rate_eff = (rate_raw == '0) ? RATE_W'(1) : rate_raw;

  // first pass: s*x / r, quotient known to fit RATE_W bits
  // second pass: tick_rate / rate
  assign div_rem     = cmd_i.start_rate ? RAMP_W'(prod_q >> RATE_W) : '0;
  assign div_dvd     = cmd_i.start_rate ?
                       {prod_q[RATE_W-1:0], {(TICK_W-RATE_W){1'b0}}} : tick_rate_q;
  assign div_divisor = cmd_i.start_rate ? ramp_steps_q : RAMP_W'(rate_eff);
  assign div_iters   = cmd_i.start_rate ? RATE_DIV_STEPS : TICK_DIV_STEPS;

  hsrc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.start_rate | cmd_i.start_tick),
    .rem_i     (div_rem),
    .dvd_i     (div_dvd),
    .divisor_i (div_divisor),
    .iters_i   (div_iters),
    .busy_o    (div_busy),
    .quot_o    (quot)
  );

  assign out_valid_o  = out_valid_q;
  assign out_coils_o  = coil_q;
  assign out_status_o = run_q;
  assign out_done_o   = done_q;
  assign out_phase_o  = phase_q;

endmodule

FILE: rtl/hsrc_ctrl.sv
// ----------------------------------------------------------------------------
// hsrc_ctrl
// sequencer for item acceptance and the interval recompute after each step
// ----------------------------------------------------------------------------
module hsrc_ctrl import hsrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  hsrc_stat_t stat_i,
  output hsrc_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o   = !stat_i.out_busy;
        cmd_o.accept = in_valid_i && in_ready_o;
        if (cmd_o.accept && stat_i.step_now) begin
          state_d = CS_SELECT;
        end
      end
      CS_SELECT: begin
        cmd_o.sel_en = 1'b1;
        state_d      = CS_MULT;
      end
      CS_MULT: begin
        cmd_o.mul_en = 1'b1;
        state_d      = CS_LAUNCH;
      end
      CS_LAUNCH: begin
        if (stat_i.need_div) begin
          cmd_o.start_rate = 1'b1;
          state_d          = CS_DIV_RATE;
        end else begin
          cmd_o.start_tick = 1'b1;
          state_d          = CS_DIV_TICK;
        end
      end
      CS_DIV_RATE: begin
        if (!stat_i.div_busy) begin
          cmd_o.start_tick = 1'b1;
          state_d          = CS_DIV_TICK;
        end
      end
      CS_DIV_TICK: begin
        if (!stat_i.div_busy) begin
          cmd_o.load_interval = 1'b1;
          state_d             = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

endmodule

FILE: rtl/half_step_stepper_ramp_controller_core.sv
// ----------------------------------------------------------------------------
// half_step_stepper_ramp_controller_core
// two-phase stepper driver, half-step coil sequence with a linear speed ramp
// ----------------------------------------------------------------------------
// usage:
//   in_i carries one command per transfer: tick, rotate (direction and
//   half-step count), lock or disable. every accepted command produces
//   exactly one transfer on out_o: coil drive, status, done flag and phase.
//   cfg_i writes step_rate, ramp_steps and tick_rate; it is always ready and
//   should only be written while no command is in flight.
// timing:
//   a result is registered in the cycle after its command is accepted.
//   commands that take no step are accepted every cycle while the
//   receiver keeps taking results. a tick that takes a step recomputes the
//   step interval before the next command is accepted: while ramping this
//   runs select, multiply, the s*x/r division and the tick_rate/rate
//   division, plus handoff steps; at cruise the s*x/r division is skipped.
// reset:
//   coils off, status idle, phase 0, tick_rate 1000, other config and motor-state registers zero.
// stall:
//   a result held by a stalled receiver stays on out_o unchanged; the next
//   command is taken in the same cycle the held result transfers.
// ----------------------------------------------------------------------------
module half_step_stepper_ramp_controller_core import hsrc_pkg::*; #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsrc_in_if.sink   in_i,
  hsrc_out_if.source out_o,
  hsrc_cfg_if.sink  cfg_i
);

  hsrc_cmd_t  cmd;
  hsrc_stat_t stat;
  logic       in_ready;

  // register writes never stall
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  // controller: owns acceptance and the recompute sequence
  hsrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: motor state doubles as the output register
  hsrc_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_op_i      (in_i.op),
    .in_dir_i     (in_i.direction),
    .in_count_i   (in_i.step_count),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_coils_o  (out_o.coils),
    .out_status_o (out_o.status),
    .out_done_o   (out_o.done_res),
    .out_phase_o  (out_o.phase)
  );

endmodule

FILE: rtl/hsrc_chk.sv
// ----------------------------------------------------------------------------
// hsrc_chk
// port-level checks for the stepper ramp controller, bound to the top level
// ----------------------------------------------------------------------------
module hsrc_chk import hsrc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [COILS_W-1:0]  coils_i,
  input logic [STATUS_W-1:0] status_i,
  input logic                done_res_i,
  input logic [PHASE_W-1:0]  phase_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(coils_i) &&
      $stable(status_i) && $stable(done_res_i) && $stable(phase_i))
    else $error("result changed while stalled");

  // a new result only follows an accepted command
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without command");

  // done only comes with the locked status
  a_done_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_res_i |-> status_i == RS_LOCK)
    else $error("done while not locked");

  // disabled means all coils off
  a_off_coils: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == RS_OFF |-> coils_i == '0)
    else $error("coils driven while disabled");

  // locked always holds a table pattern
  a_lock_coils: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == RS_LOCK |-> coils_i != '0)
    else $error("locked with coils off");

endmodule

bind half_step_stepper_ramp_controller_core hsrc_chk u_hsrc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .coils_i     (out_o.coils),
  .status_i    (out_o.status),
  .done_res_i  (out_o.done_res),
  .phase_i     (out_o.phase)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the half-step stepper ramp controller: commands go
// in through a bursty driver, every result transfer is checked field by field
// against an in-bench copy of the motor state, and register settings change
// between phases while the block is quiet
// ----------------------------------------------------------------------------
module tb_top;
  import hsrc_pkg::*;

  // quiet time before a register write or the final verdict; a stepping tick
  // keeps the divider busy after its result
  localparam int SETTLE_CYCLES = 64;
  // cycles with no transfer on any channel before the run is abandoned
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASES        = 40;
  localparam int PHASE_ITEMS   = 25;
  localparam int MAX_PRINTS    = 40;

  // half-step coil sequence: A+, A+B+, B+, B+A-, A-, A-B-, B-, A+B-
  localparam logic [3:0] HALF_STEP [8] = '{
    4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9
  };

  typedef struct {
    op_e         op;
    logic        dir;
    logic [23:0] count;
  } motor_cmd_t;

  typedef struct {
    logic [3:0]  coils;
    run_status_e status;
    logic        done;
    logic [2:0]  phase;
  } drive_t;

  // receiver back-pressure styles
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_HOLD,
    RX_SPARSE
  } rx_mode_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  hsrc_in_if  cmd_if ();
  hsrc_out_if drive_if ();
  hsrc_cfg_if cfg_if ();

  half_step_stepper_ramp_controller_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (drive_if),
    .cfg_i  (cfg_if)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the registers, at their reset values
  logic [15:0] cruise_rate = '0;
  logic [23:0] ramp_len    = '0;
  logic [19:0] tick_hz     = 20'd1000;

  // bench copy of the motor state, at its reset values
  logic [2:0]  cur_phase    = '0;
  logic [19:0] tick_wait    = '0;
  logic [19:0] step_gap     = '0;
  logic [23:0] done_steps   = '0;
  logic [23:0] target_steps = '0;
  logic        turn_ccw     = 1'b0;
  run_status_e drive_state  = RS_IDLE;
  logic [3:0]  coil_state   = '0;

  motor_cmd_t  command_q [$];       // commands waiting for the driver
  drive_t      expected_drive_q [$]; // coil/status results still owed by the block

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  logic        in_taken     = 1'b0;  // command transfer at the last rising edge

  // one line per mismatch, printing capped so a broken block stays readable
  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("%0t result %0d: %s got %0h want %0h", $realtime, results_seen, what,
               got, want);
    end
  endtask

  // apply one command to the bench motor state and return the result it owes
  function automatic drive_t advance_motor(motor_cmd_t c);
    drive_t            r;
    logic              finished;
    longint unsigned   d, t, rl, s, left, rate, hz;
    finished = 1'b0;
    case (c.op)
      OP_TICK: begin
        // ticks only matter while a move is in progress
        if (drive_state == RS_RUN) begin
          if (tick_wait < step_gap) begin
            tick_wait = tick_wait + 20'd1;
          end else begin
            // take a half-step: coils get the current pattern, then the phase moves
            coil_state = HALF_STEP[cur_phase];
            cur_phase  = turn_ccw ? cur_phase - 3'd1 : cur_phase + 3'd1;
            done_steps = done_steps + 24'd1;
            if (done_steps == target_steps) begin
              drive_state = RS_LOCK;
              finished    = 1'b1;
            end
            // linear ramp: accelerate, cruise, decelerate; short moves use a triangle
            d    = done_steps;
            t    = target_steps;
            rl   = ramp_len;
            s    = cruise_rate;
            left = (t >= d) ? t - d : 0;
            if (rl * 2 > t) begin
              rate = (d < t / 2) ? s * d / rl : s * left / rl;
            end else if (d < rl) begin
              rate = s * d / rl;
            end else if (left < rl) begin
              rate = s * left / rl;
            end else begin
              rate = s;
            end
            // a zero rate counts as one step per second
            if (rate == 0) begin
              rate = 1;
            end
            hz        = tick_hz;
            step_gap  = 20'(hz / rate);
            tick_wait = '0;
          end
        end
      end
      OP_ROTATE: begin
        target_steps = c.count;
        done_steps   = '0;
        turn_ccw     = c.dir;
        tick_wait    = '0;
        // a zero-length move locks at once and reports done
        if (c.count == '0) begin
          coil_state  = HALF_STEP[cur_phase];
          drive_state = RS_LOCK;
          finished    = 1'b1;
        end else begin
          drive_state = RS_RUN;
        end
      end
      OP_LOCK: begin
        coil_state  = HALF_STEP[cur_phase];
        drive_state = RS_LOCK;
      end
      default: begin
        coil_state  = '0;
        drive_state = RS_OFF;
      end
    endcase
    r.coils  = coil_state;
    r.status = drive_state;
    r.done   = finished;
    r.phase  = cur_phase;
    return r;
  endfunction

  // monitor: register writes, accepted commands and result transfers, all
  // sampled at the rising edge before the block's own updates land
  always @(posedge clk) begin : monitor
    motor_cmd_t c;
    drive_t     want;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_STEP_RATE:  cruise_rate = cfg_if.data[15:0];
          REG_RAMP_STEPS: ramp_len    = cfg_if.data;
          REG_TICK_RATE:  tick_hz     = cfg_if.data[19:0];
          default: ;
        endcase
      end
      if (cmd_if.valid && cmd_if.ready) begin
        c.op    = op_e'(cmd_if.op);
        c.dir   = cmd_if.direction;
        c.count = cmd_if.step_count;
        expected_drive_q.push_back(advance_motor(c));
      end
      if (drive_if.valid && drive_if.ready) begin
        if (expected_drive_q.size() == 0) begin
          note_mismatch("unexpected result, coils", drive_if.coils, '0);
        end else begin
          want = expected_drive_q.pop_front();
          if (drive_if.coils !== want.coils) begin
            note_mismatch("coils", drive_if.coils, want.coils);
          end
          if (drive_if.status !== want.status) begin
            note_mismatch("status", drive_if.status, want.status);
          end
          if (drive_if.done_res !== want.done) begin
            note_mismatch("done_res", drive_if.done_res, want.done);
          end
          if (drive_if.phase !== want.phase) begin
            note_mismatch("phase", drive_if.phase, want.phase);
          end
        end
        results_seen++;
      end
    end
    in_taken <= rst_n && cmd_if.valid && cmd_if.ready;
  end

  // watchdog: give up when no channel moves for too long
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (drive_if.valid && drive_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer in %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // command driver: bursts of back-to-back commands separated by random gaps,
  // some gaps zero so long unbroken stretches occur too
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin : driver
    motor_cmd_t c;
    if (rst_n && (in_taken || !cmd_if.valid)) begin
      if (gap_left != 0) begin
        gap_left--;
        cmd_if.valid <= 1'b0;
      end else if (command_q.size() != 0) begin
        c = command_q.pop_front();
        cmd_if.op         <= c.op;
        cmd_if.direction  <= c.dir;
        cmd_if.step_count <= c.count;
        cmd_if.valid      <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // result receiver: picks a new random back-pressure style whenever the current
  // one runs out, so stalls land on every stage of the block's work
  rx_mode_e    rx_mode     = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_tick      = 0;

  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(40, 300);
    end else begin
      rx_mode_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:  drive_if.ready <= 1'b1;
      RX_COIN:  drive_if.ready <= 1'($urandom_range(0, 1));
      RX_HOLD: begin
        if (rx_hold_left != 0) begin
          rx_hold_left--;
          drive_if.ready <= 1'b0;
        end else begin
          drive_if.ready <= 1'b1;
          if ($urandom_range(0, 5) == 0) begin
            rx_hold_left = $urandom_range(1, 10);
          end
        end
      end
      default:  drive_if.ready <= (rx_tick % 3 == 0);
    endcase
  end

  task automatic push_cmd(op_e op, logic dir, logic [23:0] count);
    motor_cmd_t c;
    c.op    = op;
    c.dir   = dir;
    c.count = count;
    command_q.push_back(c);
  endtask

  // one register transfer; valid stays high when another write follows
  task automatic write_reg(logic [1:0] idx, logic [23:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) begin
      @(posedge clk);
    end
  endtask

  // wait until every command went out and every result came back, then let
  // the divider finish any interval it is still working on
  task automatic wait_drained();
    while (command_q.size() != 0 || cmd_if.valid || expected_drive_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned k, made, n_ticks, first;
    logic [15:0] sr;
    logic [23:0] rs;
    logic [19:0] tr;
    logic [23:0] regs [3];

    // every input known from time zero
    cmd_if.valid      = 1'b0;
    cmd_if.op         = OP_TICK;
    cmd_if.direction  = 1'b0;
    cmd_if.step_count = '0;
    drive_if.ready    = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_STEP_RATE;
    cfg_if.data       = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, no stepping yet so the interval stays short:
    // tick while idle, lock, tick while locked, disable, tick while disabled,
    // zero-length move, longest move, disable in the middle of a move
    push_cmd(OP_TICK, 1'b1, 24'hFFFFFF);
    push_cmd(OP_LOCK, 1'b0, 24'h000000);
    push_cmd(OP_TICK, 1'b0, 24'h000000);
    push_cmd(OP_DISABLE, 1'b1, 24'hA5A5A5);
    push_cmd(OP_TICK, 1'b0, 24'h5A5A5A);
    push_cmd(OP_ROTATE, 1'b0, 24'h000000);
    push_cmd(OP_ROTATE, 1'b1, 24'hFFFFFF);
    push_cmd(OP_DISABLE, 1'b0, 24'h000000);
    wait_drained();

    // tick_rate zero with upper data bits set: a step on every tick, done
    // pulse at the end, ticks while locked, restart of a running move
    write_reg(REG_STEP_RATE, 24'hFFFFFF);
    write_reg(REG_RAMP_STEPS, 24'h000000);
    write_reg(REG_TICK_RATE, 24'hF00000);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    push_cmd(OP_ROTATE, 1'b1, 24'd3);
    repeat (4) push_cmd(OP_TICK, 1'b0, 24'd0);
    push_cmd(OP_ROTATE, 1'b0, 24'd5);
    push_cmd(OP_TICK, 1'b1, 24'hFFFFFF);
    push_cmd(OP_ROTATE, 1'b1, 24'hFFFFFF);
    push_cmd(OP_TICK, 1'b0, 24'd0);
    push_cmd(OP_TICK, 1'b0, 24'd0);
    push_cmd(OP_LOCK, 1'b1, 24'd7);
    push_cmd(OP_TICK, 1'b0, 24'd0);

    for (k = 0; k < PHASES; k++) begin
      wait_drained();

      // register settings: all-zero first, all-ones last (its interval is so
      // long that it would starve any later phase), random in between with
      // short intervals favored so moves actually complete
      if (k == 0) begin
        sr = '0;
        rs = '0;
        tr = '0;
      end else if (k == PHASES - 1) begin
        sr = '1;
        rs = '1;
        tr = '1;
      end else begin
        case ($urandom_range(0, 5))
          0:       sr = '0;
          1:       sr = '1;
          2, 3:    sr = 16'($urandom_range(1, 64));
          default: sr = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0:       rs = '0;
          1:       rs = '1;
          2:       rs = 24'($urandom);
          3, 4:    rs = 24'($urandom_range(1, 8));
          default: rs = 24'($urandom_range(9, 40));
        endcase
        case ($urandom_range(0, 5))
          0:       tr = '0;
          4:       tr = 20'($urandom_range(17, 200));
          default: tr = 20'($urandom_range(1, 16));
        endcase
      end
      // unused upper data bits carry noise
      regs[REG_STEP_RATE]  = {8'($urandom), sr};
      regs[REG_RAMP_STEPS] = rs;
      regs[REG_TICK_RATE]  = {4'($urandom), tr};
      first = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        write_reg(2'((first + i) % 3), regs[(first + i) % 3]);
      end
      @(negedge clk);
      cfg_if.valid <= 1'b0;
      @(posedge clk);

      // mostly complete moves (rotate then a run of ticks), the rest noise:
      // lock, disable, huge or zero moves, stray ticks with junk fields
      made = 0;
      while (made < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          6: begin
            if ($urandom_range(0, 1) == 0) begin
              push_cmd(OP_LOCK, 1'($urandom), 24'($urandom));
            end else begin
              push_cmd(OP_DISABLE, 1'($urandom), 24'($urandom));
            end
            made++;
          end
          7: begin
            push_cmd(OP_ROTATE, 1'($urandom), 24'($urandom));
            made++;
          end
          8: begin
            push_cmd(OP_ROTATE, 1'($urandom), 24'd0);
            made++;
          end
          9: begin
            n_ticks = $urandom_range(1, 6);
            repeat (n_ticks) push_cmd(OP_TICK, 1'($urandom), 24'($urandom));
            made += n_ticks;
          end
          default: begin
            if ($urandom_range(0, 4) == 0) begin
              push_cmd(OP_ROTATE, 1'($urandom), 24'($urandom_range(13, 60)));
            end else begin
              push_cmd(OP_ROTATE, 1'($urandom), 24'($urandom_range(1, 12)));
            end
            n_ticks = $urandom_range(4, 48);
            repeat (n_ticks) push_cmd(OP_TICK, 1'($urandom), 24'($urandom));
            made += n_ticks + 1;
          end
        endcase
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
